### rtl/neighborhood_threshold_marker_top_macros.svh
// Assertion macros for the neighborhood threshold marker.
`ifndef NEIGHBORHOOD_THRESHOLD_MARKER_TOP_MACROS_SVH
`define NEIGHBORHOOD_THRESHOLD_MARKER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define NTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define NTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ntm_pkg.sv
// Package: types and constants of the neighborhood threshold marker.
`timescale 1ns / 1ps

package ntm_pkg;

    localparam logic [7:0]  RESET_THRESHOLD = 8'd20;
    localparam logic [7:0]  RESET_MARKER    = 8'd111;
    localparam logic [5:0]  RESET_COLS      = 6'd10;
    localparam logic [10:0] RESET_ROWS      = 11'd5;

    localparam int NUM_SLOTS = 4;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_MARKER    = 2'd1,
        CFG_COLUMNS   = 2'd2,
        CFG_ROWS      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] row;
        logic [4:0] col;
        logic       anchored;
        logic [7:0] value;
        logic       frame_end;
    } t_result;

    // one column of the 3x3 window: rows R, R-1, R-2
    typedef struct packed {
        logic [7:0] r2;
        logic [7:0] r1;
        logic [7:0] r0;
    } t_column;

endpackage

### rtl/neighborhood_threshold_marker_top.sv
// Top level: 3x3 threshold erosion marker over a raster sample stream.
`timescale 1ns / 1ps
//
// Samples enter on the s_axis channel in raster order, one 8-bit sample per
// transfer. Each cell leaves on m_axis once its lower-right neighbor has been
// taken: tdata carries row, column and value, tuser the anchored flag, tlast
// marks the final cell of the grid. The last row waits only for its right
// neighbor, and the final sample flushes the rest of that row.
// A sample is held in the read stage register, where its window is decided, and
// its results are registered into the result slots when it leaves that stage,
// so its first result is valid once it has passed both registers.
// The input accepts one sample per cycle while each sample yields at most one
// result and m_axis_tready is high; the line memory has one read and one write
// port and is read and written back one column per cycle while samples flow.
// Samples of the last column of a row and of the last row yield up to two
// results, the final sample of the grid up to four; the output port then sets
// the pace at one result per cycle and the input waits for the group to drain.
// Reset clears position, pipeline and result slots and loads the default
// register values; the line memory is not cleared and is filled by the first
// two rows of a frame. When m_axis_tready is low, results wait in the slot
// register and the input stalls once the decision stage holds a sample with results.

module neighborhood_threshold_marker_top
    import ntm_pkg::*;
#(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [9:0] out_row, [14:10] out_col, [22:15] cell_value
    output logic        m_axis_tuser,   // [0] anchored
    output logic        m_axis_tlast    // frame_end
);

`include "neighborhood_threshold_marker_top_macros.svh"

    localparam int ROWS_CAP_I = (MAX_ROWS > 2047) ? 2047 : MAX_ROWS;
    localparam int ROW_W      = (ROWS_CAP_I > 1) ? $clog2(ROWS_CAP_I) : 1;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam logic [10:0] ROWS_CAP = 11'(ROWS_CAP_I);
    localparam logic [5:0]  COLS_CAP = 6'(MAX_COLS);

    // configuration
    logic [7:0]  r_threshold;
    logic [7:0]  r_marker;
    logic [5:0]  r_grid_cols;
    logic [10:0] r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RESET_THRESHOLD;
            r_marker    <= RESET_MARKER;
            r_grid_cols <= RESET_COLS;
            r_grid_rows <= RESET_ROWS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                CFG_MARKER:    r_marker    <= i_cfg_data[7:0];
                CFG_COLUMNS:   r_grid_cols <= i_cfg_data[5:0];
                CFG_ROWS:      r_grid_rows <= i_cfg_data;
            endcase
        end
    end

    logic [5:0]  eff_cols;
    logic [5:0]  cols_m1;
    logic [10:0] eff_rows;
    logic [10:0] rows_m1;

    always_comb begin
        if (r_grid_cols == 6'd0) begin
            eff_cols = 6'd1;
        end else if (r_grid_cols > COLS_CAP) begin
            eff_cols = COLS_CAP;
        end else begin
            eff_cols = r_grid_cols;
        end
        if (r_grid_rows == 11'd0) begin
            eff_rows = 11'd1;
        end else if (r_grid_rows > ROWS_CAP) begin
            eff_rows = ROWS_CAP;
        end else begin
            eff_rows = r_grid_rows;
        end
        cols_m1 = eff_cols - 6'd1;
        rows_m1 = eff_rows - 11'd1;
    end

    // input position
    logic [ROW_W-1:0] r_in_row;
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] pos_row;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] nxt_row;
    logic [COL_W-1:0] nxt_col;
    logic             in_xfer;

    always_comb begin
        if ((11'(r_in_row) >= eff_rows) || (6'(r_in_col) >= eff_cols)) begin
            pos_row = '0;
            pos_col = '0;
        end else begin
            pos_row = r_in_row;
            pos_col = r_in_col;
        end
        if (6'(pos_col) != cols_m1) begin
            nxt_col = pos_col + COL_W'(1);
            nxt_row = pos_row;
        end else begin
            nxt_col = '0;
            nxt_row = (11'(pos_row) != rows_m1) ? pos_row + ROW_W'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (in_xfer) begin
            r_in_row <= nxt_row;
            r_in_col <= nxt_col;
        end
    end

    // read stage
    logic             r_s1_valid;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    logic [7:0]       r_s1_sample;
    logic             s1_adv;

    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_row    <= pos_row;
            r_s1_col    <= pos_col;
            r_s1_sample <= s_axis_tdata;
        end
    end

    // line memory: per column {row R-2, row R-1} as seen by the next row
    logic [15:0] r_mem [MAX_COLS];
    logic [15:0] r_rd;
    logic [15:0] wr_word;

    assign wr_word = {r_rd[7:0], r_s1_sample};

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_col] <= wr_word;
        end
        if (in_xfer) begin
            if (s1_adv && (r_s1_col == pos_col)) begin
                r_rd <= wr_word;
            end else begin
                r_rd <= r_mem[pos_col];
            end
        end
    end

    // window columns C-1 and C-2
    t_column r_w1;
    t_column r_w2;
    t_column cur;

    assign cur = '{r2: r_rd[15:8], r1: r_rd[7:0], r0: r_s1_sample};

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_w2 <= r_w1;
            r_w1 <= cur;
        end
    end

    // decisions
    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge1;
    logic             col_ge2;
    logic             at_last_col;
    logic             at_last_row;
    logic [2:0]       up_ok;
    logic [2:0]       lo_ok;
    logic [3:0]       emit;
    t_result          n_slot [NUM_SLOTS];
    logic [10:0]      row_ext;
    logic [10:0]      row_up_ext;
    logic [5:0]       col_ext;
    logic [5:0]       col_lf_ext;

    function automatic logic col_up(input t_column c, input logic [7:0] th,
                                    input logic ge2);
        col_up = (c.r0 > th) && (c.r1 > th) && (!ge2 || (c.r2 > th));
    endfunction

    function automatic logic col_lo(input t_column c, input logic [7:0] th,
                                    input logic ge1);
        col_lo = (c.r0 > th) && (!ge1 || (c.r1 > th));
    endfunction

    always_comb begin
        row_ge1     = (r_s1_row != '0);
        row_ge2     = (11'(r_s1_row) >= 11'd2);
        col_ge1     = (r_s1_col != '0);
        col_ge2     = (6'(r_s1_col) >= 6'd2);
        at_last_col = (6'(r_s1_col) == cols_m1);
        at_last_row = (11'(r_s1_row) == rows_m1);

        up_ok[0] = col_up(cur, r_threshold, row_ge2);
        up_ok[1] = col_up(r_w1, r_threshold, row_ge2);
        up_ok[2] = col_up(r_w2, r_threshold, row_ge2);
        lo_ok[0] = col_lo(cur, r_threshold, row_ge1);
        lo_ok[1] = col_lo(r_w1, r_threshold, row_ge1);
        lo_ok[2] = col_lo(r_w2, r_threshold, row_ge1);

        emit[0] = row_ge1 && col_ge1;
        emit[1] = row_ge1 && at_last_col;
        emit[2] = at_last_row && col_ge1;
        emit[3] = at_last_row && at_last_col;

        row_ext    = 11'(r_s1_row);
        row_up_ext = 11'(r_s1_row - ROW_W'(1));
        col_ext    = 6'(r_s1_col);
        col_lf_ext = 6'(r_s1_col - COL_W'(1));

        n_slot[0].row       = row_up_ext[9:0];
        n_slot[0].col       = col_lf_ext[4:0];
        n_slot[0].anchored  = up_ok[0] && up_ok[1] && (!col_ge2 || up_ok[2]);
        n_slot[0].value     = n_slot[0].anchored ? r_marker : r_w1.r1;
        n_slot[0].frame_end = 1'b0;

        n_slot[1].row       = row_up_ext[9:0];
        n_slot[1].col       = col_ext[4:0];
        n_slot[1].anchored  = up_ok[0] && (!col_ge1 || up_ok[1]);
        n_slot[1].value     = n_slot[1].anchored ? r_marker : cur.r1;
        n_slot[1].frame_end = 1'b0;

        n_slot[2].row       = row_ext[9:0];
        n_slot[2].col       = col_lf_ext[4:0];
        n_slot[2].anchored  = lo_ok[0] && lo_ok[1] && (!col_ge2 || lo_ok[2]);
        n_slot[2].value     = n_slot[2].anchored ? r_marker : r_w1.r0;
        n_slot[2].frame_end = 1'b0;

        n_slot[3].row       = row_ext[9:0];
        n_slot[3].col       = col_ext[4:0];
        n_slot[3].anchored  = lo_ok[0] && (!col_ge1 || lo_ok[1]);
        n_slot[3].value     = n_slot[3].anchored ? r_marker : cur.r0;
        n_slot[3].frame_end = 1'b1;
    end

    // result slots, drained lowest first
    t_result    r_slot [NUM_SLOTS];
    logic [3:0] r_mask;
    logic [3:0] n_mask;
    logic [1:0] sel;
    logic [3:0] sel_bit;
    logic       out_xfer;
    logic       single;
    logic       grp_free;
    logic       grp_load;
    t_result    head;

    always_comb begin
        priority if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        sel_bit  = 4'b0001 << sel;
        head     = r_slot[sel];
        out_xfer = m_axis_tvalid && m_axis_tready;
        single   = ((r_mask & (r_mask - 4'd1)) == 4'd0);
        grp_free = (r_mask == 4'd0) || (single && m_axis_tready);
        s1_adv   = r_s1_valid && ((emit == 4'd0) || grp_free);
        grp_load = s1_adv && (emit != 4'd0);
        n_mask   = out_xfer ? (r_mask & ~sel_bit) : r_mask;
        if (grp_load) begin
            n_mask = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 4'd0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_load) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

    assign m_axis_tvalid = (r_mask != 4'd0);
    assign m_axis_tdata  = {1'b0, head.value, head.col, head.row};
    assign m_axis_tuser  = head.anchored;
    assign m_axis_tlast  = head.frame_end;

    `NTM_ASSERT_NOW(a_stall_needs_s1, !s_axis_tready, r_s1_valid, "input stalled with empty stage")
    `NTM_ASSERT_NEXT(a_fwd_word, in_xfer && s1_adv && (r_s1_col == pos_col), r_rd == $past(wr_word), "line memory forward missed")
    `NTM_ASSERT_NEXT(a_slot_load, grp_load, r_mask == $past(emit), "result slots loaded over pending results")
    `NTM_ASSERT_NEXT(a_drain_last, out_xfer && single && !grp_load, !m_axis_tvalid, "result repeated after drain")

endmodule
